// File: src/quant4_block_scaled_dot_assert.svh
// Assertion macros used by the checker of this block.
// Each one expects signals named clk and rst_n in the scope where it is used.
`ifndef QUANT4_BLOCK_SCALED_DOT_ASSERT_SVH
`define QUANT4_BLOCK_SCALED_DOT_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define QBSD_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define QBSD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/qbsd_pkg.sv
`default_nettype none

package qbsd_pkg;

    // Block geometry
    localparam int unsigned BLOCK_VALUES = 32;
    localparam int unsigned WT_BYTES     = BLOCK_VALUES / 2;
    localparam int unsigned LANES        = 4;
    localparam int unsigned LANE_BYTES   = WT_BYTES / LANES;
    localparam int unsigned LANE_BITS    = 8 * LANE_BYTES;

    // Input tdata layout
    localparam int unsigned WT_LSB     = 0;
    localparam int unsigned WT_BITS    = 8 * WT_BYTES;
    localparam int unsigned ACT_LSB    = WT_LSB + WT_BITS;
    localparam int unsigned ACT_BITS   = 8 * BLOCK_VALUES;
    localparam int unsigned HALF_ACT   = ACT_BITS / 2;
    localparam int unsigned SCALE_LSB  = ACT_LSB + ACT_BITS;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned IN_TDATA_W = SCALE_LSB + HALF_W;

    // Datapath widths
    localparam int unsigned LANE_W = 15;   // 8 terms, |term| <= 1024
    localparam int unsigned DOT_W  = 17;   // 32 terms, range -32512..32768
    localparam int unsigned MAG_W  = 16;
    localparam int unsigned EXP_W  = 5;
    localparam int unsigned MAN_W  = 10;
    localparam int unsigned SIG_W  = MAN_W + 1;
    localparam int unsigned PROD_W = MAG_W + SIG_W;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned OUT_TDATA_W = ACC_W;

    // Constants
    localparam logic signed [4:0]   NIB_OFFSET  = 5'sd8;
    localparam logic [EXP_W-1:0]    EXP_SPECIAL = 5'h1F;
    localparam logic [CFG_W-1:0]    SCALE_RESET = 32'h0100_0000;
    localparam logic [ACC_W-1:0]    S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0]    S64_MIN     = 64'h8000_0000_0000_0000;

    typedef logic signed [LANE_W-1:0] lane_sum_t;

    // Per-block control carried down the front pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic fault;
    } qbsd_ctl_t;

    // Finished row handed from the accumulator to the finishing pipeline
    typedef struct packed {
        logic push;
        logic fault;
    } qbsd_row_t;

endpackage

`default_nettype wire

// File: src/qbsd_lane.sv
`default_nettype none

module qbsd_lane (
    input  logic                            clk,
    input  logic                            en,
    input  logic [qbsd_pkg::LANE_BITS-1:0]  wts,      // weight bytes of this lane
    input  logic [qbsd_pkg::LANE_BITS-1:0]  acts_lo,  // activations for low nibbles
    input  logic [qbsd_pkg::LANE_BITS-1:0]  acts_hi,  // activations for high nibbles
    output qbsd_pkg::lane_sum_t             sum
);
    import qbsd_pkg::*;

    lane_sum_t sum_next;
    lane_sum_t sum_reg;

    // Partial dot over this lane's bytes, both nibbles
    always_comb
    begin
        logic signed [4:0]  nlo;
        logic signed [4:0]  nhi;
        logic signed [7:0]  alo;
        logic signed [7:0]  ahi;
        logic signed [12:0] plo;
        logic signed [12:0] phi;
        sum_next = '0;
        for (int i = 0; i < LANE_BYTES; i++)
        begin
            nlo = signed'({1'b0, wts[8*i +: 4]}) - NIB_OFFSET;
            nhi = signed'({1'b0, wts[8*i+4 +: 4]}) - NIB_OFFSET;
            alo = signed'(acts_lo[8*i +: 8]);
            ahi = signed'(acts_hi[8*i +: 8]);
            plo = nlo * alo;
            phi = nhi * ahi;
            sum_next = sum_next + LANE_W'(plo) + LANE_W'(phi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// File: src/qbsd_block_prod.sv
`default_nettype none

module qbsd_block_prod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_last,
    input  logic [qbsd_pkg::HALF_W-1:0]   in_scale,
    input  qbsd_pkg::lane_sum_t           lane_sum [qbsd_pkg::LANES],
    output qbsd_pkg::qbsd_ctl_t           out_ctl,
    output logic [qbsd_pkg::ACC_W-1:0]    addend
);
    import qbsd_pkg::*;

    // Stage 1: control and scale, in step with the lane registers
    qbsd_ctl_t          p1_ctl_reg;
    logic [HALF_W-1:0]  p1_scale_reg;

    // Stage 2: merged dot magnitude and decoded scale
    qbsd_ctl_t          p2_ctl_reg,  p2_ctl_next;
    logic [MAG_W-1:0]   p2_mag_reg,  p2_mag_next;
    logic               p2_neg_reg,  p2_neg_next;
    logic [EXP_W-1:0]   p2_exp_reg;
    logic [MAN_W-1:0]   p2_man_reg;

    // Stage 3: integer product and shift amount
    qbsd_ctl_t          p3_ctl_reg;
    logic [PROD_W-1:0]  p3_prod_reg, p3_prod_next;
    logic [EXP_W-1:0]   p3_sh_reg,   p3_sh_next;
    logic               p3_neg_reg;

    // Stage 4: signed fixed-point addend
    qbsd_ctl_t          p4_ctl_reg;
    logic [ACC_W-1:0]   p4_add_reg,  p4_add_next;

    // Merge lanes, take magnitude, decode half-precision fields
    always_comb
    begin
        logic signed [DOT_W-1:0] dot;
        dot = '0;
        for (int j = 0; j < LANES; j++)
        begin
            dot = dot + DOT_W'(lane_sum[j]);
        end
        p2_neg_next       = dot[DOT_W-1] ^ p1_scale_reg[HALF_W-1];
        p2_mag_next       = dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
        p2_ctl_next       = p1_ctl_reg;
        p2_ctl_next.fault = (p1_scale_reg[MAN_W +: EXP_W] == EXP_SPECIAL);
    end

    // Magnitude times significand; Inf/NaN blocks contribute nothing
    always_comb
    begin
        logic [SIG_W-1:0] sig;
        sig = {(p2_exp_reg != '0), p2_man_reg};
        p3_prod_next = {{(PROD_W-MAG_W){1'b0}}, p2_mag_reg}
                     * {{(PROD_W-SIG_W){1'b0}}, sig};
        if (p2_ctl_reg.fault)
        begin
            p3_prod_next = '0;
        end
        p3_sh_next = (p2_exp_reg == '0) ? '0 : p2_exp_reg - EXP_W'(1);
    end

    // Align to 24 fraction bits and apply sign
    always_comb
    begin
        logic [ACC_W-1:0] mag;
        mag = {{(ACC_W-PROD_W){1'b0}}, p3_prod_reg} << p3_sh_reg;
        p4_add_next = p3_neg_reg ? (~mag + ACC_W'(1)) : mag;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
            p2_ctl_reg <= '0;
            p3_ctl_reg <= '0;
            p4_ctl_reg <= '0;
        end
        else if (en)
        begin
            p1_ctl_reg <= '{valid: in_valid, last: in_last, fault: 1'b0};
            p2_ctl_reg <= p2_ctl_next;
            p3_ctl_reg <= p2_ctl_reg;
            p4_ctl_reg <= p3_ctl_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_scale_reg <= in_scale;
            p2_mag_reg   <= p2_mag_next;
            p2_neg_reg   <= p2_neg_next;
            p2_exp_reg   <= p1_scale_reg[MAN_W +: EXP_W];
            p2_man_reg   <= p1_scale_reg[MAN_W-1:0];
            p3_prod_reg  <= p3_prod_next;
            p3_sh_reg    <= p3_sh_next;
            p3_neg_reg   <= p2_neg_reg;
            p4_add_reg   <= p4_add_next;
        end
    end

    assign out_ctl = p4_ctl_reg;
    assign addend  = p4_add_reg;

endmodule

`default_nettype wire

// File: src/qbsd_accum.sv
`default_nettype none

module qbsd_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  qbsd_pkg::qbsd_ctl_t         in_ctl,
    input  logic [qbsd_pkg::ACC_W-1:0]  addend,
    output qbsd_pkg::qbsd_row_t         row,
    output logic [qbsd_pkg::ACC_W-1:0]  row_sum
);
    import qbsd_pkg::*;

    logic [ACC_W-1:0] running_sum_reg, running_sum_next;
    logic             scale_fault_reg, scale_fault_next;
    logic [ACC_W-1:0] sat_sum;
    logic             take;

    assign take = en && in_ctl.valid;

    // Saturating add of the block product
    always_comb
    begin
        logic [ACC_W-1:0] raw;
        raw = running_sum_reg + addend;
        if ((running_sum_reg[ACC_W-1] == addend[ACC_W-1])
            && (raw[ACC_W-1] != running_sum_reg[ACC_W-1]))
        begin
            sat_sum = running_sum_reg[ACC_W-1] ? S64_MIN : S64_MAX;
        end
        else
        begin
            sat_sum = raw;
        end
    end

    // Update, or hand the row off and clear on the last block
    always_comb
    begin
        running_sum_next = running_sum_reg;
        scale_fault_next = scale_fault_reg;
        if (take)
        begin
            if (in_ctl.last)
            begin
                running_sum_next = '0;
                scale_fault_next = 1'b0;
            end
            else
            begin
                running_sum_next = sat_sum;
                scale_fault_next = scale_fault_reg | in_ctl.fault;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            scale_fault_reg <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            scale_fault_reg <= scale_fault_next;
        end
    end

    assign row.push  = take && in_ctl.last;
    assign row.fault = scale_fault_reg | in_ctl.fault;
    assign row_sum   = sat_sum;

endmodule

`default_nettype wire

// File: src/qbsd_finish.sv
`default_nettype none

module qbsd_finish (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qbsd_pkg::qbsd_row_t               row,
    input  logic [qbsd_pkg::ACC_W-1:0]        row_sum,
    input  logic [qbsd_pkg::CFG_W-1:0]        act_scale,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qbsd_pkg::ACC_W-1:0]        out_value,
    output logic                              out_fault
);
    import qbsd_pkg::*;

    // F1: sign and magnitude
    logic             f1_v_reg;
    logic             f1_neg_reg, f1_fault_reg;
    logic [ACC_W-1:0] f1_mag_reg;
    // F2: two 32x32 partial products
    logic             f2_v_reg;
    logic             f2_neg_reg, f2_fault_reg;
    logic [ACC_W-1:0] f2_lo_reg, f2_hi_reg;
    // F3: combined, truncated quotient and flags
    logic             f3_v_reg;
    logic             f3_neg_reg, f3_fault_reg, f3_ovf_reg, f3_sticky_reg;
    logic [ACC_W-1:0] f3_q_reg;
    logic [ACC_W-1:0] mid;
    // Output register
    logic             out_v_reg;
    logic             out_fault_reg;
    logic [ACC_W-1:0] out_value_reg, out_value_next;

    logic out_take, f3_take, f2_take, f1_take;

    // A stage loads when empty or when its contents move on
    assign out_take = !out_v_reg || out_ready;
    assign f3_take  = !f3_v_reg || out_take;
    assign f2_take  = !f2_v_reg || f3_take;
    assign f1_take  = !f1_v_reg || f2_take;

    assign mid = f2_hi_reg + {32'b0, f2_lo_reg[63:32]};

    // Saturate, or negate with rounding toward minus infinity
    always_comb
    begin
        if (f3_ovf_reg)
        begin
            out_value_next = f3_neg_reg ? S64_MIN : S64_MAX;
        end
        else if (f3_neg_reg)
        begin
            out_value_next = f3_sticky_reg ? ~f3_q_reg : ~f3_q_reg + ACC_W'(1);
        end
        else
        begin
            out_value_next = f3_q_reg;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            f3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_take)
            begin
                f1_v_reg <= row.push;
            end
            if (f2_take)
            begin
                f2_v_reg <= f1_v_reg;
            end
            if (f3_take)
            begin
                f3_v_reg <= f2_v_reg;
            end
            if (out_take)
            begin
                out_v_reg <= f3_v_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (f1_take)
        begin
            f1_neg_reg   <= row_sum[ACC_W-1];
            f1_mag_reg   <= row_sum[ACC_W-1] ? ~row_sum + ACC_W'(1) : row_sum;
            f1_fault_reg <= row.fault;
        end
        if (f2_take)
        begin
            f2_lo_reg    <= {32'b0, f1_mag_reg[31:0]} * {32'b0, act_scale};
            f2_hi_reg    <= {32'b0, f1_mag_reg[63:32]} * {32'b0, act_scale};
            f2_neg_reg   <= f1_neg_reg;
            f2_fault_reg <= f1_fault_reg;
        end
        if (f3_take)
        begin
            f3_ovf_reg    <= |mid[63:55];
            f3_q_reg      <= {1'b0, mid[54:0], f2_lo_reg[31:24]};
            f3_sticky_reg <= |f2_lo_reg[23:0];
            f3_neg_reg    <= f2_neg_reg;
            f3_fault_reg  <= f2_fault_reg;
        end
        if (out_take)
        begin
            out_value_reg <= out_value_next;
            out_fault_reg <= f3_fault_reg;
        end
    end

    assign take      = f1_take;
    assign out_valid = out_v_reg;
    assign out_value = out_value_reg;
    assign out_fault = out_fault_reg;

endmodule

`default_nettype wire

// File: src/quant4_block_scaled_dot.sv
// Path of a last block to m_tvalid: lane/p1 regs, p2, p3, p4, then F1, F2, F3, output register.
// Throughput: one block per cycle unless stalled; four lanes each form an 8-term partial dot.
// s_tready low only while a last block waits on three full finishing stages plus a full output.
// Reset (rst_n low, async): accumulator and fault flag clear, activation_scale
// returns to 1.0, all pipeline stages empty.
`default_nettype none

module quant4_block_scaled_dot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Fields from bit 0: weights_low, weights_high, acts_a, acts_b, acts_c,
    // acts_d, block_scale
    input  logic [qbsd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tlast,    // final_block
    // Fields from bit 0: dot_value
    output logic [qbsd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: bad_scale
    output logic                                 m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [qbsd_pkg::CFG_W-1:0]           cfg_wr_data // activation_scale
);
    import qbsd_pkg::*;

    logic [CFG_W-1:0]  act_scale_reg;
    logic              front_adv;
    logic              fin_take;
    lane_sum_t         lane_sum [LANES];
    qbsd_ctl_t         p4_ctl;
    logic [ACC_W-1:0]  addend;
    qbsd_row_t         row;
    logic [ACC_W-1:0]  row_sum;

    // Activation scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            act_scale_reg <= cfg_wr_data;
        end
    end

    // Front pipeline holds only when a last block meets a full finishing chain
    assign front_adv = !(p4_ctl.valid && p4_ctl.last) || fin_take;
    assign s_tready  = front_adv;

    // Lanes
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        qbsd_lane u_lane (
            .clk     (clk),
            .en      (front_adv),
            .wts     (s_tdata[WT_LSB + LANE_BITS*j +: LANE_BITS]),
            .acts_lo (s_tdata[ACT_LSB + LANE_BITS*j +: LANE_BITS]),
            .acts_hi (s_tdata[ACT_LSB + HALF_ACT + LANE_BITS*j +: LANE_BITS]),
            .sum     (lane_sum[j])
        );
    end

    qbsd_block_prod u_block_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (front_adv),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_scale (s_tdata[SCALE_LSB +: HALF_W]),
        .lane_sum (lane_sum),
        .out_ctl  (p4_ctl),
        .addend   (addend)
    );

    qbsd_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (front_adv),
        .in_ctl  (p4_ctl),
        .addend  (addend),
        .row     (row),
        .row_sum (row_sum)
    );

    qbsd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row),
        .row_sum   (row_sum),
        .act_scale (act_scale_reg),
        .take      (fin_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_fault (m_tuser)
    );

endmodule

`default_nettype wire

// File: src/qbsd_checker.sv
`default_nettype none

`include "quant4_block_scaled_dot_assert.svh"

module qbsd_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [qbsd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 m_tuser
);
    import qbsd_pkg::*;

    localparam int unsigned PIPE_SLOTS = 8;   // front stages plus finishing stages
    localparam int unsigned PEND_W     = 4;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              row_in, row_out;

    assign row_in  = s_tvalid && s_tready && s_tlast;
    assign row_out = m_tvalid && m_tready;

    // Rows accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg + PEND_W'(row_in) - PEND_W'(row_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `QBSD_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `QBSD_CHECK(a_no_extra_row, m_tvalid, pend_reg != '0, "result without a pending row")
    `QBSD_CHECK(a_pend_bound, 1'b1, pend_reg <= PEND_W'(PIPE_SLOTS),
        "more rows in flight than pipeline slots")
    `QBSD_CHECK(a_stall_cause, !s_tready, m_tvalid && !m_tready,
        "input stalled while output is free")

endmodule

bind quant4_block_scaled_dot qbsd_checker u_qbsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qbsd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int PIPE_LATENCY   = 7;
    localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY + 4;
    localparam int STALL_LIMIT    = 5000;
    localparam int NIBBLE_BIAS    = 8;
    localparam int FLOOD_BLOCKS   = 270;   // enough max-magnitude blocks to pin the sum

    localparam logic [15:0] HALF_ONE        = 16'h3C00;
    localparam logic [15:0] HALF_NEG_ONE    = 16'hBC00;
    localparam logic [15:0] HALF_POS_INF    = 16'h7C00;
    localparam logic [15:0] HALF_NEG_INF    = 16'hFC00;
    localparam logic [15:0] HALF_QNAN       = 16'h7E00;
    localparam logic [15:0] HALF_MIN_SUB    = 16'h0001;
    localparam logic [15:0] HALF_NEG_ZERO   = 16'h8000;
    localparam logic [15:0] HALF_MAX_FINITE = 16'h7BFF;
    localparam logic [15:0] HALF_MIN_NORMAL = 16'h0400;

    // One Q4_0 weight block with its activations
    typedef struct {
        logic [63:0] weights_low;
        logic [63:0] weights_high;
        logic [63:0] acts_a;
        logic [63:0] acts_b;
        logic [63:0] acts_c;
        logic [63:0] acts_d;
        logic [15:0] block_scale;
        logic        final_block;
    } q4_block_t;

    typedef struct {
        logic signed [63:0] dot_value;
        logic               bad_scale;
    } row_result_t;

    typedef struct {
        q4_block_t          blk;
        bit                 typed;
        logic signed [63:0] want_dot;
        logic               want_bad;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic                   s_tlast;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;

    // Predictor state
    logic signed [63:0] row_sum;
    logic               row_fault;
    logic [31:0]        act_scale;

    row_result_t   pending_rows[$];
    directed_row_t directed[$];

    int src_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatches   = 0;
    int blocks_sent  = 0;
    int rows_checked = 0;
    int fault_rows   = 0;
    int sat_rows     = 0;
    int scale_writes = 0;

    quant4_block_scaled_dot dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tlast     (s_tlast),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Print and count one mismatch
    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("ERROR %0t: %s", $time, what);
    endtask

    // Fold one block into the row sum; on the last block return the scaled row
    function automatic void absorb_block(input q4_block_t blk, output bit emits,
                                         output row_result_t res);
        logic [127:0]       wts;
        logic [255:0]       acts;
        logic [7:0]         wb;
        logic signed [7:0]  a_lo;
        logic signed [7:0]  a_hi;
        logic [4:0]         ex;
        logic [9:0]         man;
        logic [63:0]        dmag;
        logic [63:0]        term;
        logic signed [64:0] wide;
        logic signed [96:0] wide_sum;
        logic signed [96:0] wide_scale;
        logic signed [96:0] q;
        int                 dot;

        ex  = blk.block_scale[14:10];
        man = blk.block_scale[9:0];
        if (ex == EXP_SPECIAL)
            row_fault = 1'b1;
        else
        begin
            wts  = {blk.weights_high, blk.weights_low};
            acts = {blk.acts_d, blk.acts_c, blk.acts_b, blk.acts_a};
            dot  = 0;
            // low nibble pairs with activation k, high nibble with k + 16
            for (int k = 0; k < WT_BYTES; k++)
            begin
                wb   = wts[8*k +: 8];
                a_lo = acts[8*k +: 8];
                a_hi = acts[8*(k + WT_BYTES) +: 8];
                dot += (int'(wb[3:0]) - NIBBLE_BIAS) * int'(a_lo)
                     + (int'(wb[7:4]) - NIBBLE_BIAS) * int'(a_hi);
            end
            dmag = 64'(dot < 0 ? -dot : dot);
            // exact product in units of 2^-24
            if (ex == 5'd0)
                term = dmag * 64'(man);
            else
                term = (dmag * 64'({1'b1, man})) << (ex - 1);
            if ((dot < 0) ^ blk.block_scale[15])
                term = -term;
            wide = {row_sum[63], row_sum} + {term[63], term};
            if (wide[64] != wide[63])
                row_sum = wide[64] ? S64_MIN : S64_MAX;
            else
                row_sum = wide[63:0];
        end

        emits = blk.final_block;
        res.dot_value = '0;
        res.bad_scale = 1'b0;
        if (emits)
        begin
            // sum * scale, floor shift by 24, then clamp to 64 bits
            wide_sum   = row_sum;
            wide_scale = {65'd0, act_scale};
            q = (wide_sum * wide_scale) >>> 24;
            if (q[96:63] != {34{q[96]}})
            begin
                res.dot_value = q[96] ? S64_MIN : S64_MAX;
                sat_rows++;
            end
            else
                res.dot_value = q[63:0];
            res.bad_scale = row_fault;
            row_sum   = '0;
            row_fault = 1'b0;
        end
    endfunction

    function automatic q4_block_t uniform_block(input logic [7:0] wbyte,
                                                input logic [7:0] act_lo,
                                                input logic [7:0] act_hi,
                                                input logic [15:0] half, input bit last);
        q4_block_t blk;
        blk.weights_low  = {8{wbyte}};
        blk.weights_high = {8{wbyte}};
        blk.acts_a       = {8{act_lo}};
        blk.acts_b       = {8{act_lo}};
        blk.acts_c       = {8{act_hi}};
        blk.acts_d       = {8{act_hi}};
        blk.block_scale  = half;
        blk.final_block  = last;
        return blk;
    endfunction

    function automatic logic [63:0] rand_weight_lane();
        case ($urandom_range(7))
            0:       return 64'h0;
            1:       return '1;
            2:       return {8{8'h88}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand_act_lane();
        case ($urandom_range(7))
            0:       return {8{8'h80}};
            1:       return {8{8'h7F}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic q4_block_t rand_block(input bit last);
        q4_block_t  blk;
        logic [4:0] ex;
        blk.weights_low  = rand_weight_lane();
        blk.weights_high = rand_weight_lane();
        blk.acts_a       = rand_act_lane();
        blk.acts_b       = rand_act_lane();
        blk.acts_c       = rand_act_lane();
        blk.acts_d       = rand_act_lane();
        // mostly moderate exponents, some subnormal, huge, Inf and NaN
        case ($urandom_range(19))
            0:       ex = EXP_SPECIAL;
            1, 2:    ex = 5'd0;
            3, 4:    ex = 5'($urandom_range(1, 30));
            default: ex = 5'($urandom_range(8, 18));
        endcase
        blk.block_scale = {1'($urandom), ex, 10'($urandom)};
        if ($urandom_range(3) == 0)
            blk.block_scale[9:0] = '0;
        blk.final_block = last;
        return blk;
    endfunction

    // Offer one block, predict it once the transfer happens
    task automatic push_block(input q4_block_t blk, input bit typed,
                              input logic signed [63:0] typed_dot, input logic typed_bad);
        row_result_t res;
        bit          emits;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blk.block_scale, blk.acts_d, blk.acts_c, blk.acts_b, blk.acts_a,
                     blk.weights_high, blk.weights_low};
        s_tlast  <= blk.final_block;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_block(blk, emits, res);
        blocks_sent++;
        if (emits)
        begin
            if (typed)
            begin
                res.dot_value = typed_dot;
                res.bad_scale = typed_bad;
            end
            pending_rows.push_back(res);
        end
    endtask

    task automatic send_random_rows(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                push_block(rand_block(i == len - 1), 1'b0, '0, 1'b0);
            sent += len;
        end
    endtask

    // Drive the sum into the rail, then add a few random blocks, the last of which ends the row
    task automatic send_saturating_row(input bit negative);
        logic [7:0] act;
        int         extra;
        act   = negative ? 8'h7F : 8'h80;
        extra = $urandom_range(1, 3);
        for (int i = 0; i < FLOOD_BLOCKS; i++)
            push_block(uniform_block(8'h00, act, act, HALF_MAX_FINITE, 1'b0), 1'b0, '0, 1'b0);
        for (int i = 0; i < extra; i++)
            push_block(rand_block(i == extra - 1), 1'b0, '0, 1'b0);
    endtask

    // Hold the sender until every row is back and the pipe has emptied
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_activation_scale(input logic [31:0] value);
        quiesce();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        act_scale = value;
        scale_writes++;
    endtask

    task automatic add_row(input q4_block_t blk, input bit typed,
                           input logic signed [63:0] want_dot, input logic want_bad);
        directed_row_t row;
        row.blk      = blk;
        row.typed    = typed;
        row.want_dot = want_dot;
        row.want_bad = want_bad;
        directed.push_back(row);
    endtask

    // Directed blocks, all run at the reset scale of 1.0
    task automatic build_directed();
        q4_block_t blk;
        // all weights at the offset point: dot is zero
        add_row(uniform_block(8'h88, 8'h7F, 8'h80, HALF_ONE, 1'b1), 1'b1, '0, 1'b0);
        // largest dot, -8 * -128 over 32 terms
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_ONE, 1'b1), 1'b1,
                64'sd32768 <<< 24, 1'b0);
        // most negative dot
        add_row(uniform_block(8'h00, 8'h7F, 8'h7F, HALF_ONE, 1'b1), 1'b1,
                -(64'sd32512 <<< 24), 1'b0);
        add_row(uniform_block(8'hFF, 8'h80, 8'h80, HALF_ONE, 1'b1), 1'b1,
                -(64'sd28672 <<< 24), 1'b0);
        // Inf scale adds nothing and raises the fault
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_POS_INF, 1'b1), 1'b1, '0, 1'b1);
        // fault from an earlier block of the row sticks to the row
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_NEG_INF, 1'b0), 1'b0, '0, 1'b0);
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_ONE, 1'b1), 1'b1,
                64'sd32768 <<< 24, 1'b1);
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_QNAN, 1'b1), 1'b1, '0, 1'b1);
        // smallest subnormal, signed zeros
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_MIN_SUB, 1'b1), 1'b1, 64'sd32768, 1'b0);
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_NEG_ZERO, 1'b1), 1'b1, '0, 1'b0);
        add_row(uniform_block(8'h00, 8'h80, 8'h80, 16'h0000, 1'b1), 1'b1, '0, 1'b0);
        // largest finite scale
        add_row(uniform_block(8'h00, 8'h80, 8'h80, HALF_MAX_FINITE, 1'b1), 1'b1,
                64'sd2047 <<< 44, 1'b0);
        add_row(uniform_block(8'h00, 8'h7F, 8'h7F, 16'hFBFF, 1'b1), 1'b0, '0, 1'b0);
        // all-ones and all-zeros inputs
        add_row(uniform_block(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1), 1'b1, '0, 1'b1);
        add_row(uniform_block(8'h00, 8'h00, 8'h00, 16'h0000, 1'b1), 1'b1, '0, 1'b0);
        // distinct bytes to check nibble/activation pairing
        blk.weights_low  = 64'h0123_4567_89AB_CDEF;
        blk.weights_high = 64'hFEDC_BA98_7654_3210;
        blk.acts_a       = 64'h0102_0304_0506_0708;
        blk.acts_b       = 64'hF1E2_D3C4_B5A6_9788;
        blk.acts_c       = 64'h7F80_0011_22EE_33DD;
        blk.acts_d       = 64'h1020_3040_5060_7080;
        blk.block_scale  = 16'h3555;
        blk.final_block  = 1'b0;
        add_row(blk, 1'b0, '0, 1'b0);
        blk.weights_low  = 64'hFEDC_BA98_7654_3210;
        blk.weights_high = 64'h0123_4567_89AB_CDEF;
        blk.block_scale  = 16'hB800;
        blk.final_block  = 1'b1;
        add_row(blk, 1'b0, '0, 1'b0);
        add_row(uniform_block(8'h0F, 8'h01, 8'h02, HALF_MIN_NORMAL, 1'b0), 1'b0, '0, 1'b0);
        add_row(uniform_block(8'hF0, 8'hFF, 8'h7F, 16'h83FF, 1'b0), 1'b0, '0, 1'b0);
        add_row(uniform_block(8'h5A, 8'hC3, 8'h3C, HALF_NEG_ONE, 1'b1), 1'b0, '0, 1'b0);
    endtask

    // Receiver backpressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    // Check each result transfer against the oldest pending row
    always @(posedge clk)
    begin : result_check
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
                flag_mismatch($sformatf("unexpected result dot=%h bad=%b", m_tdata, m_tuser));
            else
            begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (want.bad_scale)
                    fault_rows++;
                if (m_tdata !== want.dot_value)
                    flag_mismatch($sformatf("dot_value %h, expected %h",
                                            m_tdata, want.dot_value));
                if (m_tuser !== want.bad_scale)
                    flag_mismatch($sformatf("bad_scale %b, expected %b",
                                            m_tuser, want.bad_scale));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d rows pending",
                 STALL_LIMIT, pending_rows.size());
        $display("Verification failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        row_sum     = '0;
        row_fault   = 1'b0;
        act_scale   = SCALE_RESET;

        build_directed();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles a little, receiver a lot
        src_idle_pct = 20;
        rcv_idle_pct = 82;
        foreach (directed[i])
            push_block(directed[i].blk, directed[i].typed, directed[i].want_dot,
                       directed[i].want_bad);
        send_random_rows(330);
        set_activation_scale(32'hFFFF_FFFF);
        send_saturating_row(1'b0);
        send_random_rows(200);

        // sender idles a lot, receiver a little
        src_idle_pct = 82;
        rcv_idle_pct = 20;
        set_activation_scale(32'h0000_0000);
        send_random_rows(230);
        set_activation_scale($urandom);
        send_saturating_row(1'b1);
        send_random_rows(200);

        // no idling on either side
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        set_activation_scale(32'h0080_0000);
        send_random_rows(250);
        set_activation_scale($urandom);
        send_random_rows(230);

        quiesce();
        $display("Sent %0d blocks, checked %0d row results (%0d with a bad scale, %0d clamped)",
                 blocks_sent, rows_checked, fault_rows, sat_rows);
        $display("Ran %0d activation_scale settings besides reset, with %0d mismatches",
                 scale_writes, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/qbsd_pkg.sv
src/qbsd_lane.sv
src/qbsd_block_prod.sv
src/qbsd_accum.sv
src/qbsd_finish.sv
src/quant4_block_scaled_dot.sv
src/qbsd_checker.sv
tb/sv/testbench.sv
